// ===== design/ts2e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts2e_pkg
// Shared types and constants for the time string to epoch seconds converter.
// ----------------------------------------------------------------------------
package ts2e_pkg;

  // character codes
  localparam logic [7:0] ChrNul  = 8'h00;
  localparam logic [7:0] ChrZero = 8'h30;
  localparam logic [7:0] ChrNine = 8'h39;
  localparam logic [7:0] ChrPm   = 8'h70;

  // string positions
  localparam logic [3:0] PosMonthLo = 4'd1;
  localparam logic [3:0] PosDayLo   = 4'd3;
  localparam logic [3:0] PosHourLo  = 4'd5;
  localparam logic [3:0] PosYearHi  = 4'd8;
  localparam logic [3:0] PosYearLo  = 4'd9;
  localparam logic [3:0] PosAfter   = 4'd10;
  localparam logic [3:0] PosSkip    = 4'd11;

  // calendar constants
  localparam logic [7:0] EpochYearOfs = 8'd70;   // 1970 - 1900
  localparam logic [8:0] DaysPerYear  = 9'd365;
  localparam logic [6:0] HourWrap     = 7'd24;
  localparam logic [7:0] HourMax      = 8'd23;
  localparam logic [7:0] PmOffset     = 8'd12;
  localparam logic [6:0] MinuteMax    = 7'd59;
  localparam logic [6:0] MonthMax     = 7'd12;
  localparam logic [6:0] DayMax       = 7'd31;
  localparam logic [3:0] MonthMarch   = 4'd3;

  // reset value of the year register
  localparam logic [7:0] CurYearRst = 8'd70;

  // status codes
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAYS,
    ST_HOURS,
    ST_MINS,
    ST_SECS,
    ST_PASS,
    ST_FAIL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic char_en;
    logic calc_days;
    logic calc_hours;
    logic calc_mins;
    logic calc_secs;
    logic load_out;
    logic out_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_end;
    logic fin_err;
    logic out_free;
  } sts_t;

  // days in the months before the given month of a common year
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    d = 9'd0;
    unique case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/ts2e_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts2e_dpath
// Character parser registers, seconds accumulator and output register.
// ----------------------------------------------------------------------------
module ts2e_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     char_i,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  ts2e_pkg::cmd_t cmd_i,
  output ts2e_pkg::sts_t sts_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic           out_status_o
);

  logic [7:0]  cur_year_q;
  logic [3:0]  pos_q, pos_d;
  logic [3:0]  first_q, first_d;
  logic [3:0]  month_q, month_d;
  logic [5:0]  day_q, day_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  minute_q, minute_d;
  logic [6:0]  year_q, year_d;
  logic        year_given_q, year_given_d;
  logic        pm_q, pm_d;
  logic        perr_q, perr_d;
  logic [31:0] secs_q, secs_d;
  logic        out_valid_q;
  logic        out_status_q;

  logic        digit;
  logic [3:0]  dval;
  logic [6:0]  pair;
  logic        hour_wrap;
  logic [7:0]  hour_eff;
  logic [5:0]  day_eff;
  logic [7:0]  yr;
  logic [7:0]  n_years;
  logic [16:0] year_days;
  logic [17:0] days_total;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_year_q <= ts2e_pkg::CurYearRst;
    end else if (cfg_we_i) begin
      cur_year_q <= cfg_wdata_i;
    end
  end

  // digit decode
  assign digit = (char_i >= ts2e_pkg::ChrZero) && (char_i <= ts2e_pkg::ChrNine);
  assign dval  = digit ? 4'(char_i - ts2e_pkg::ChrZero) : 4'd0;
  assign pair  = 7'(7'(first_q) * 7'd10) + 7'(dval);

  // per character parse step
  always_comb begin
    pos_d        = pos_q;
    first_d      = first_q;
    month_d      = month_q;
    day_d        = day_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    year_d       = year_q;
    year_given_d = year_given_q;
    pm_d         = pm_q;
    perr_d       = perr_q;
    if (cmd_i.load_out) begin
      pos_d        = '0;
      first_d      = '0;
      month_d      = '0;
      day_d        = '0;
      hour_d       = '0;
      minute_d     = '0;
      year_d       = '0;
      year_given_d = 1'b0;
      pm_d         = 1'b0;
      perr_d       = 1'b0;
    end else if (cmd_i.char_en) begin
      if (pos_q < ts2e_pkg::PosYearHi) begin
        if (!digit) begin
          perr_d = 1'b1;
          pos_d  = ts2e_pkg::PosSkip;
        end else if (!pos_q[0]) begin
          first_d = dval;
          pos_d   = pos_q + 4'd1;
        end else begin
          unique case (pos_q)
            ts2e_pkg::PosMonthLo: begin
              if (pair < 7'd1 || pair > ts2e_pkg::MonthMax) perr_d = 1'b1;
              else month_d = pair[3:0];
            end
            ts2e_pkg::PosDayLo: begin
              if (pair < 7'd1 || pair > ts2e_pkg::DayMax) perr_d = 1'b1;
              else day_d = pair[5:0];
            end
            ts2e_pkg::PosHourLo: begin
              hour_d = pair;
            end
            default: begin
              if (pair > ts2e_pkg::MinuteMax) perr_d = 1'b1;
              else minute_d = pair;
            end
          endcase
          pos_d = perr_d ? ts2e_pkg::PosSkip : pos_q + 4'd1;
        end
      end else begin
        pos_d = ts2e_pkg::PosSkip;
        unique case (pos_q)
          ts2e_pkg::PosYearHi: begin
            if (digit) begin
              first_d = dval;
              pos_d   = ts2e_pkg::PosYearLo;
            end else if (char_i == ts2e_pkg::ChrPm) begin
              pm_d = 1'b1;
            end
          end
          ts2e_pkg::PosYearLo: begin
            if (digit) begin
              year_d       = pair;
              year_given_d = 1'b1;
              pos_d        = ts2e_pkg::PosAfter;
            end
          end
          ts2e_pkg::PosAfter: begin
            if (char_i == ts2e_pkg::ChrPm) pm_d = 1'b1;
          end
          default: begin
            pos_d = ts2e_pkg::PosSkip;
          end
        endcase
      end
    end
  end

  // hour 24 rolls into the next day, then the afternoon mark
  assign hour_wrap = (hour_q == ts2e_pkg::HourWrap);
  assign hour_eff  = (hour_wrap ? 8'd0 : 8'(hour_q)) + (pm_q ? ts2e_pkg::PmOffset : 8'd0);
  assign day_eff   = day_q + 6'(hour_wrap);

  // whole years since 1970 and the days of the date
  assign yr         = year_given_q ? 8'(year_q) : cur_year_q;
  assign n_years    = (yr > ts2e_pkg::EpochYearOfs) ? yr - ts2e_pkg::EpochYearOfs : 8'd0;
  assign year_days  = 17'(n_years) * 17'(ts2e_pkg::DaysPerYear);
  assign days_total = 18'(year_days)
                    + 18'((9'(n_years) + 9'd1) >> 2)
                    + 18'((yr[1:0] == 2'b00) && (month_q >= ts2e_pkg::MonthMarch))
                    + 18'(ts2e_pkg::days_before(month_q))
                    + 18'(day_eff) - 18'd1;

  // seconds accumulator, one scaling step per cycle
  always_comb begin
    secs_d = secs_q;
    if (cmd_i.calc_days) begin
      secs_d = 32'(days_total);
    end else if (cmd_i.calc_hours) begin
      secs_d = secs_q * 32'd24 + 32'(hour_eff);
    end else if (cmd_i.calc_mins) begin
      secs_d = secs_q * 32'd60 + 32'(minute_q);
    end else if (cmd_i.calc_secs) begin
      secs_d = secs_q * 32'd60;
    end
  end

  // parse state and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      first_q      <= '0;
      month_q      <= '0;
      day_q        <= '0;
      hour_q       <= '0;
      minute_q     <= '0;
      year_q       <= '0;
      year_given_q <= 1'b0;
      pm_q         <= 1'b0;
      perr_q       <= 1'b0;
      secs_q       <= '0;
    end else begin
      pos_q        <= pos_d;
      first_q      <= first_d;
      month_q      <= month_d;
      day_q        <= day_d;
      hour_q       <= hour_d;
      minute_q     <= minute_d;
      year_q       <= year_d;
      year_given_q <= year_given_d;
      pm_q         <= pm_d;
      perr_q       <= perr_d;
      secs_q       <= secs_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.out_status;
    end
  end

  // status towards the controller
  assign sts_o.is_end   = (char_i == ts2e_pkg::ChrNul);
  assign sts_o.fin_err  = perr_q || (pos_q < ts2e_pkg::PosYearHi)
                       || (hour_eff > ts2e_pkg::HourMax)
                       || (month_q < 4'd1) || (7'(month_q) > ts2e_pkg::MonthMax);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;

endmodule

// ===== design/ts2e_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts2e_ctrl
// Sequencer: per character parse, then the four conversion steps.
// ----------------------------------------------------------------------------
module ts2e_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ts2e_pkg::sts_t sts_i,
  output ts2e_pkg::cmd_t cmd_o
);

  ts2e_pkg::state_e state_q, state_d;
  logic             in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ts2e_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ts2e_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.is_end) begin
          state_d = sts_i.fin_err ? ts2e_pkg::ST_FAIL : ts2e_pkg::ST_DAYS;
        end
      end
      ts2e_pkg::ST_DAYS:  state_d = ts2e_pkg::ST_HOURS;
      ts2e_pkg::ST_HOURS: state_d = ts2e_pkg::ST_MINS;
      ts2e_pkg::ST_MINS:  state_d = ts2e_pkg::ST_SECS;
      ts2e_pkg::ST_SECS:  state_d = ts2e_pkg::ST_PASS;
      ts2e_pkg::ST_PASS, ts2e_pkg::ST_FAIL: begin
        if (sts_i.out_free) state_d = ts2e_pkg::ST_IDLE;
      end
      default: state_d = ts2e_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ts2e_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.char_en = in_valid_i && !sts_i.is_end;
      end
      ts2e_pkg::ST_DAYS:  cmd_o.calc_days  = 1'b1;
      ts2e_pkg::ST_HOURS: cmd_o.calc_hours = 1'b1;
      ts2e_pkg::ST_MINS:  cmd_o.calc_mins  = 1'b1;
      ts2e_pkg::ST_SECS:  cmd_o.calc_secs  = 1'b1;
      ts2e_pkg::ST_PASS: begin
        cmd_o.load_out   = sts_i.out_free;
        cmd_o.out_status = ts2e_pkg::StatusOk;
      end
      ts2e_pkg::ST_FAIL: begin
        cmd_o.load_out   = sts_i.out_free;
        cmd_o.out_status = ts2e_pkg::StatusErr;
      end
      default: ;
    endcase
  end

  // checks
  a_end_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && sts_i.is_end |=> !in_ready_o)
    else $error("input not stalled after end of string");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result loaded over a waiting result");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.char_en, cmd_o.calc_days, cmd_o.calc_hours, cmd_o.calc_mins,
              cmd_o.calc_secs, cmd_o.load_out}))
    else $error("more than one datapath command");

  a_days_then_hours: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.calc_days |=> cmd_o.calc_hours)
    else $error("conversion sequence broken");

endmodule

// ===== design/time_string_to_epoch_seconds.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_string_to_epoch_seconds
// Converts an MMDDHHMM[YY][p] character string to seconds since 1970.
// ----------------------------------------------------------------------------
// Non-zero character beats are taken while the sequencer is idle. The zero byte
// that ends the string produces one status beat: a valid string is converted
// in four sequencer steps (days, hours, minutes, seconds) and its status is then
// loaded into the output register; an invalid string goes straight to its error
// status. Either load waits while the output register is still held by an
// earlier status beat. Input is not taken while the conversion runs; characters
// are taken while a result waits downstream. The converted seconds are held
// internally; on error they are kept as they were. current_year is written
// through cfg_we_i and applies to strings without a year.
// ----------------------------------------------------------------------------
module time_string_to_epoch_seconds (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,     // current_year
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] char_code
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata     // [0] status, [7:1] zero
);

  ts2e_pkg::cmd_t cmd;
  ts2e_pkg::sts_t sts;
  logic           out_status;

  // sequencer
  ts2e_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // parser and arithmetic
  ts2e_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_i       (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {7'd0, out_status};

endmodule
